// File: hw/rtl/ttid_pkg.sv
// Shared types, constants and the helper function of the tap tempo interval detector.
package ttid_pkg;

	localparam int STAMP_W     = 32;
	localparam int RATIO_W     = 8;
	localparam int BPM_W       = 26;
	localparam int PROD_W      = STAMP_W + RATIO_W;
	localparam int SUM_W       = STAMP_W + 2;
	localparam int DIGIT_W     = 4;
	localparam int SUM_DIGITS  = (SUM_W + DIGIT_W - 1) / DIGIT_W;
	localparam int SUM_SR_W    = SUM_DIGITS * DIGIT_W;
	localparam int RING_DEPTH  = 4;
	localparam int SLOT_W      = 2;
	localparam int CH_IN_W     = 2;
	localparam int IN_DATA_W   = 64;
	localparam int OUT_DATA_W  = 96;
	localparam int OUT_USER_W  = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int DIV_STEPS   = BPM_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [BPM_W-1:0]   BPM_DIVIDEND = BPM_W'(60000000);
	localparam logic [RATIO_W-1:0] NUM_RESET    = RATIO_W'(5);
	localparam logic [RATIO_W-1:0] DEN_RESET    = RATIO_W'(4);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_NUM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_DEN = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_CALC,
		ST_DECIDE,
		ST_DIV,
		ST_DONE
	} ttid_state_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] q;
		logic [1:0]         r;
	} ttid_div3_t;

	// One radix-16 digit of a division by three: v = remainder * 16 + next digit.
	// Quotient digit by multiplying with 43/128, exact for v below 48.
	function automatic ttid_div3_t div3_digit(input logic [DIGIT_W+1:0] v);
		logic [11:0] prod;
		ttid_div3_t  res;
		prod  = 12'(v) * 12'd43;
		res.q = prod[10:7];
		res.r = 2'(v - (6'(res.q) * 6'd3));
		return res;
	endfunction

endpackage

// File: hw/rtl/ttid_bpm_div.sv
// Bit-serial restoring divider that turns the average interval into beats per minute.
module ttid_bpm_div import ttid_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [STAMP_W-1:0]  divisor,
	output logic                done,
	output logic [BPM_W-1:0]    quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic                 zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [STAMP_W-1:0]   div_q;
	logic [BPM_W-1:0]     dvd_sr_q;
	logic [BPM_W-1:0]     rem_q;
	logic [BPM_W-1:0]     quo_q;
	logic [BPM_W:0]       shifted;
	logic                 ge;
	logic [BPM_W:0]       diff;

	assign shifted = {rem_q, dvd_sr_q[BPM_W-1]};
	assign ge      = (STAMP_W'(shifted) >= div_q);
	assign diff    = shifted - div_q[BPM_W:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q    <= divisor;
			zero_q   <= (divisor == '0);
			dvd_sr_q <= BPM_DIVIDEND;
			rem_q    <= '0;
			quo_q    <= '0;
		end else if (busy_q) begin
			// remainder stays below 2^26, as it never exceeds the dividend prefix
			rem_q    <= ge ? diff[BPM_W-1:0] : shifted[BPM_W-1:0];
			quo_q    <= {quo_q[BPM_W-2:0], ge};
			dvd_sr_q <= {dvd_sr_q[BPM_W-2:0], 1'b0};
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? BPM_DIVIDEND : quo_q;

endmodule

// File: hw/rtl/tap_tempo_interval_detector.sv
// Top level of the tap tempo interval detector: stream ports, ring store and lock logic.
// An ignored request (repeated stamp or unknown channel) goes straight to its result; an
// accepted one reads the ring, then runs the 9-digit division by three beside the 8-step
// ratio products, and a lock adds the 26-step bit-serial divider for the tempo. One request
// is in work at a time; the next is taken once the result sits in the output register.
// Reset clears every store at once.
module tap_tempo_interval_detector import ttid_pkg::*; #(
	parameter int CHANNELS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] trigger_time, [63:32] now_ticks
	input  logic [CH_IN_W-1:0]    s_tuser,   // [1:0] channel
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [25:0] tempo_bpm, [57:26] beat_interval,
	                                         // [89:58] lock_stamp, [95:90] zero
	output logic [OUT_USER_W-1:0] m_tuser,   // [1:0] out_channel, [2] accepted, [3] locked
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [RATIO_W-1:0]    cfg_data
);

	localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W       = CH_W + SLOT_W;
	localparam int RING_ENTRIES = CHANNELS * RING_DEPTH;

	ttid_state_t state_q, state_d;

	// configuration
	logic [RATIO_W-1:0] num_q, den_q;

	// per-channel stores
	logic [STAMP_W-1:0] last_trig_q [CHANNELS];
	logic [SLOT_W-1:0]  slot_q      [CHANNELS];
	logic [BPM_W-1:0]   bpm_st_q    [CHANNELS];
	logic [STAMP_W-1:0] int_st_q    [CHANNELS];
	logic [STAMP_W-1:0] tick_st_q   [CHANNELS];

	// stamp ring: memory with one valid bit per entry, unwritten entries read as zero
	logic [STAMP_W-1:0]      ring_mem [RING_ENTRIES];
	logic [RING_ENTRIES-1:0] ring_vld_q;
	logic [STAMP_W-1:0]      rd_data_q;
	logic                    rd_vld_q;
	logic [STAMP_W-1:0]      rd_val;
	logic [ADDR_W-1:0]       rd_addr;
	logic [ADDR_W-1:0]       wr_addr;

	// request held while in work
	logic [CH_IN_W-1:0] ch_q;
	logic [CH_W-1:0]    idx_q;
	logic               ok_q;
	logic               acc_q;
	logic               lock_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [STAMP_W-1:0] tick_q;
	logic [SLOT_W-1:0]  slot_cur_q;
	logic [3:0]         step_q;

	// intervals, ratio products and average
	logic [STAMP_W-1:0]  prev_q, d0_q, d1_q, d2_q;
	logic [STAMP_W-1:0]  diff_prev;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_SR_W-1:0] sum_sr_q;
	logic [SUM_SR_W-1:0] quo3_q;
	logic [1:0]          rem3_q;
	ttid_div3_t          dig;
	logic [RATIO_W-1:0]  num_sr_q, den_sr_q;
	logic [PROD_W-1:0]   p0n_q, p1d_q, p2d_q, p0d_q, p2n_q;
	logic [STAMP_W-1:0]  avg;
	logic                lock_c;
	logic [BPM_W-1:0]    bpm_q;

	// tempo divider
	logic             div_start;
	logic             div_done;
	logic [BPM_W-1:0] div_quo;

	// input decode
	logic [CH_IN_W-1:0] in_ch;
	logic [CH_W-1:0]    in_idx;
	logic               in_ok;
	logic [STAMP_W-1:0] in_stamp;
	logic [STAMP_W-1:0] in_tick;
	logic               in_acc;
	logic               s_fire;

	// output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;
	logic                  out_free;
	logic                  out_load;
	logic                  rd_en;
	logic                  wr_en;
	logic [BPM_W-1:0]      res_bpm;
	logic [STAMP_W-1:0]    res_int;
	logic [STAMP_W-1:0]    res_tick;

	assign in_ch    = s_tuser;
	assign in_idx   = CH_W'(in_ch);
	assign in_ok    = (5'(in_ch) < 5'(CHANNELS));
	assign in_stamp = s_tdata[STAMP_W-1:0];
	assign in_tick  = s_tdata[IN_DATA_W-1:STAMP_W];
	assign in_acc   = in_ok && (in_stamp != last_trig_q[in_idx]);
	assign s_fire   = s_tvalid && s_tready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_RESET;
			den_q <= DEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RATIO_NUM: num_q <= cfg_data;
				REG_RATIO_DEN: den_q <= cfg_data;
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Sequencer
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_fire) state_d = in_acc ? ST_READ : ST_DONE;
			ST_READ:   if (step_q[1:0] == 2'd3) state_d = ST_SUM;
			ST_SUM:    state_d = ST_CALC;
			ST_CALC:   if (step_q == 4'(SUM_DIGITS - 1)) state_d = ST_DECIDE;
			ST_DECIDE: state_d = lock_c ? ST_DIV : ST_DONE;
			ST_DIV:    if (div_done) state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:   s_tready  = 1'b1;
			ST_READ: begin
				rd_en = 1'b1;
				wr_en = (step_q[1:0] == 2'd0);
			end
			ST_DECIDE: div_start = lock_c;
			ST_DONE:   out_load  = out_free;
			default: ;
		endcase
	end

	//--------------------------------------------------------------------------
	// Stamp ring
	//--------------------------------------------------------------------------
	// Write the new stamp into its slot, read the three older slots after it.
	assign wr_addr = {idx_q, slot_cur_q};
	assign rd_addr = {idx_q, SLOT_W'(slot_cur_q + step_q[1:0] + 2'd1)};
	assign rd_val  = rd_vld_q ? rd_data_q : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= stamp_q;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				ring_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= ring_vld_q[rd_addr];
			end
		end
	end

	//--------------------------------------------------------------------------
	// Datapath
	//--------------------------------------------------------------------------
	assign diff_prev = rd_val - prev_q;
	assign dig       = div3_digit({rem3_q, sum_sr_q[SUM_SR_W-1 -: DIGIT_W]});
	assign avg       = quo3_q[STAMP_W-1:0];
	assign lock_c    = (p1d_q < p0n_q) && (p2d_q < p0n_q) && (p0d_q < p2n_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					ch_q       <= in_ch;
					idx_q      <= in_idx;
					ok_q       <= in_ok;
					acc_q      <= in_acc;
					lock_q     <= 1'b0;
					stamp_q    <= in_stamp;
					tick_q     <= in_tick;
					slot_cur_q <= slot_q[in_idx];
					step_q     <= '0;
				end
			end
			ST_READ: begin
				// read data is registered and arrives in the cycle after its address
				case (step_q[1:0])
					2'd1: prev_q <= rd_val;
					2'd2: begin
						d0_q   <= diff_prev;
						prev_q <= rd_val;
					end
					2'd3: begin
						d1_q  <= diff_prev;
						d2_q  <= stamp_q - rd_val;
						sum_q <= SUM_W'(d0_q) + SUM_W'(diff_prev);
					end
					default: ;
				endcase
				step_q <= step_q + 1'b1;
			end
			ST_SUM: begin
				sum_sr_q <= SUM_SR_W'(sum_q + SUM_W'(d2_q));
				quo3_q   <= '0;
				rem3_q   <= '0;
				num_sr_q <= num_q;
				den_sr_q <= den_q;
				p0n_q    <= '0;
				p1d_q    <= '0;
				p2d_q    <= '0;
				p0d_q    <= '0;
				p2n_q    <= '0;
				step_q   <= '0;
			end
			ST_CALC: begin
				// divide the sum by three, one hex digit a cycle
				sum_sr_q <= {sum_sr_q[SUM_SR_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
				quo3_q   <= {quo3_q[SUM_SR_W-DIGIT_W-1:0], dig.q};
				rem3_q   <= dig.r;
				// ratio products, one bit of num and den a cycle, msb first
				if (step_q < 4'(RATIO_W)) begin
					p0n_q    <= {p0n_q[PROD_W-2:0], 1'b0} + (num_sr_q[RATIO_W-1] ? PROD_W'(d0_q) : '0);
					p2n_q    <= {p2n_q[PROD_W-2:0], 1'b0} + (num_sr_q[RATIO_W-1] ? PROD_W'(d2_q) : '0);
					p1d_q    <= {p1d_q[PROD_W-2:0], 1'b0} + (den_sr_q[RATIO_W-1] ? PROD_W'(d1_q) : '0);
					p2d_q    <= {p2d_q[PROD_W-2:0], 1'b0} + (den_sr_q[RATIO_W-1] ? PROD_W'(d2_q) : '0);
					p0d_q    <= {p0d_q[PROD_W-2:0], 1'b0} + (den_sr_q[RATIO_W-1] ? PROD_W'(d0_q) : '0);
					num_sr_q <= {num_sr_q[RATIO_W-2:0], 1'b0};
					den_sr_q <= {den_sr_q[RATIO_W-2:0], 1'b0};
				end
				step_q <= step_q + 1'b1;
			end
			ST_DECIDE: lock_q <= lock_c;
			ST_DIV:    if (div_done) bpm_q <= div_quo;
			default: ;
		endcase
	end

	ttid_bpm_div u_bpm_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (avg),
		.done     (div_done),
		.quotient (div_quo)
	);

	//--------------------------------------------------------------------------
	// Commit and result
	//--------------------------------------------------------------------------
	// Report the channel's stores as they stand after this request.
	always_comb begin
		res_bpm  = '0;
		res_int  = '0;
		res_tick = '0;
		if (ok_q) begin
			res_bpm  = lock_q ? bpm_q  : bpm_st_q[idx_q];
			res_int  = lock_q ? avg    : int_st_q[idx_q];
			res_tick = lock_q ? tick_q : tick_st_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_trig_q[i] <= '0;
				slot_q[i]      <= '0;
				bpm_st_q[i]    <= '0;
				int_st_q[i]    <= '0;
				tick_st_q[i]   <= '0;
			end
		end else if (out_load && acc_q) begin
			last_trig_q[idx_q] <= stamp_q;
			slot_q[idx_q]      <= slot_cur_q + 1'b1;
			if (lock_q) begin
				bpm_st_q[idx_q]  <= bpm_q;
				int_st_q[idx_q]  <= avg;
				tick_st_q[idx_q] <= tick_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{(OUT_DATA_W - BPM_W - 2 * STAMP_W){1'b0}}, res_tick, res_int, res_bpm};
			m_tuser_q <= {lock_q, acc_q, ch_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: hw/rtl/ttid_chk.sv
// Port-level assertions of the tap tempo interval detector and their binding.
module ttid_chk import ttid_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [CH_IN_W-1:0]    s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request in work: drop ready after an accept
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	// a lock only follows a stored stamp
	a_lock_needs_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[3] && !m_tuser[2]))
		else $error("locked without accepted");

	// tempo never exceeds its saturation value
	a_bpm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[BPM_W-1:0] <= BPM_DIVIDEND)
		else $error("tempo out of range");

endmodule

bind tap_tempo_interval_detector ttid_chk u_ttid_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: verif/tap_tempo_interval_detector_test.sv
// Self-checking testbench of the tap tempo interval detector with its own tempo predictor.
`timescale 1ns / 1ps

module tap_tempo_interval_detector_test;
	import ttid_pkg::*;

	localparam int          CHANNELS        = 4;
	localparam int unsigned MICROS_PER_MIN  = 60_000_000;
	localparam int          TIMEOUT_CYCLES  = 600_000;
	localparam int          TAIL_CYCLES     = 64;
	localparam int          TAPS_PER_PHASE  = 173;
	localparam int          PHASES          = 10;

	// One trigger request as it travels on the request stream.
	typedef struct packed {
		logic [CH_IN_W-1:0] ch;
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] tick;
	} tap_t;

	// One result as it travels on the result stream, spare bits of tdata included.
	typedef struct packed {
		logic [CH_IN_W-1:0] ch;
		logic               acc;
		logic               lck;
		logic [BPM_W-1:0]   bpm;
		logic [STAMP_W-1:0] interval;
		logic [STAMP_W-1:0] lock_tick;
		logic [5:0]         pad;
	} tempo_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [CH_IN_W-1:0]    s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [RATIO_W-1:0]    cfg_data  = '0;

	// Predicted copy of the block's stores and ratio registers.
	logic [STAMP_W-1:0] tap_ring [CHANNELS][RING_DEPTH];
	logic [SLOT_W-1:0]  ring_slot     [CHANNELS];
	logic [STAMP_W-1:0] prev_stamp    [CHANNELS];
	logic [BPM_W-1:0]   held_bpm      [CHANNELS];
	logic [STAMP_W-1:0] held_interval [CHANNELS];
	logic [STAMP_W-1:0] held_tick     [CHANNELS];
	logic [RATIO_W-1:0] tol_num = NUM_RESET;
	logic [RATIO_W-1:0] tol_den = DEN_RESET;

	tap_t          tap_queue     [$];
	tempo_result_t pending_tempo [$];

	// Handshakes seen at the last rising edge; read by the falling-edge processes.
	bit req_taken = 1'b0;
	bit res_taken = 1'b0;
	bit cfg_taken = 1'b0;

	int taps_issued = 0;
	int taps_done   = 0;
	int fault_count = 0;

	// Idle state of both sides: per-request waits and calm stretches without any.
	int send_gap   = 0;
	int send_calm  = 0;
	int recv_stall = 0;
	int recv_calm  = 0;
	bit stall_armed = 1'b0;

	// Per-channel tap generator: last stamp sent, nominal period and jitter divisor.
	logic [STAMP_W-1:0] gen_stamp  [CHANNELS];
	logic [STAMP_W-1:0] gen_period [CHANNELS];
	logic [STAMP_W-1:0] gen_spread [CHANNELS];

	tap_tempo_interval_detector #(
		.CHANNELS(CHANNELS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// Advance the predicted state by one trigger and return the result it causes.
	function automatic tempo_result_t track_tempo(input tap_t tap);
		tempo_result_t      res;
		logic [SLOT_W-1:0]  slot;
		logic [STAMP_W-1:0] t0, t1, t2, g0, g1, g2, mean;
		logic [63:0]        lim0, lim2, sum;
		res     = '0;
		res.ch  = tap.ch;
		if (tap.stamp != prev_stamp[tap.ch]) begin
			slot = ring_slot[tap.ch];
			tap_ring[tap.ch][slot] = tap.stamp;
			t0 = tap_ring[tap.ch][SLOT_W'(slot + 1)];
			t1 = tap_ring[tap.ch][SLOT_W'(slot + 2)];
			t2 = tap_ring[tap.ch][SLOT_W'(slot + 3)];
			// Intervals wrap modulo 2^32, the products and the sum do not.
			g0   = t1 - t0;
			g1   = t2 - t1;
			g2   = tap.stamp - t2;
			lim0 = 64'(g0) * 64'(tol_num);
			lim2 = 64'(g2) * 64'(tol_num);
			if (64'(g1) * 64'(tol_den) < lim0 && 64'(g2) * 64'(tol_den) < lim0 &&
			    64'(g0) * 64'(tol_den) < lim2) begin
				sum  = 64'(g0) + 64'(g1) + 64'(g2);
				mean = STAMP_W'(sum / 64'd3);
				held_bpm[tap.ch]      = (mean == '0) ? BPM_W'(MICROS_PER_MIN)
				                                     : BPM_W'(MICROS_PER_MIN / mean);
				held_interval[tap.ch] = mean;
				held_tick[tap.ch]     = tap.tick;
				res.lck = 1'b1;
			end
			prev_stamp[tap.ch] = tap.stamp;
			ring_slot[tap.ch]  = SLOT_W'(slot + 1);
			res.acc = 1'b1;
		end
		res.bpm       = held_bpm[tap.ch];
		res.interval  = held_interval[tap.ch];
		res.lock_tick = held_tick[tap.ch];
		return res;
	endfunction

	// Rising edge: note every handshake, mirror register writes, predict and check.
	always @(posedge clk) begin : watch
		tap_t          tap;
		tempo_result_t seen, want;
		if (!arst_n) begin
			req_taken = 1'b0;
			res_taken = 1'b0;
			cfg_taken = 1'b0;
		end else begin
			req_taken = s_tvalid && s_tready;
			res_taken = m_tvalid && m_tready;
			cfg_taken = cfg_valid && cfg_ready;
			if (cfg_taken) begin
				case (cfg_index)
					REG_RATIO_NUM: tol_num = cfg_data;
					REG_RATIO_DEN: tol_den = cfg_data;
					default: ;
				endcase
			end
			if (req_taken) begin
				tap = '{ch: s_tuser, stamp: s_tdata[31:0], tick: s_tdata[63:32]};
				pending_tempo.push_back(track_tempo(tap));
				taps_done++;
			end
			if (res_taken) begin
				seen = '{ch: m_tuser[1:0], acc: m_tuser[2], lck: m_tuser[3],
				         bpm: m_tdata[25:0], interval: m_tdata[57:26],
				         lock_tick: m_tdata[89:58], pad: m_tdata[95:90]};
				if (pending_tempo.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected result: ch=%0d acc=%0b lck=%0b bpm=%0d int=%0d tick=%h",
						         seen.ch, seen.acc, seen.lck, seen.bpm, seen.interval,
						         seen.lock_tick);
				end else begin
					want = pending_tempo.pop_front();
					if (seen.ch != want.ch || seen.acc != want.acc || seen.lck != want.lck ||
					    seen.bpm != want.bpm || seen.interval != want.interval ||
					    seen.lock_tick != want.lock_tick || seen.pad != want.pad) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("mismatch exp: ch=%0d acc=%0b lck=%0b bpm=%0d int=%0d tick=%h pad=%h",
							         want.ch, want.acc, want.lck, want.bpm, want.interval,
							         want.lock_tick, want.pad);
							$display("         got: ch=%0d acc=%0b lck=%0b bpm=%0d int=%0d tick=%h pad=%h",
							         seen.ch, seen.acc, seen.lck, seen.bpm, seen.interval,
							         seen.lock_tick, seen.pad);
						end
					end
				end
			end
		end
	end

	// Request driver: hold a request until taken, then wait the drawn gap and send the next.
	always @(negedge clk) begin : drive_taps
		tap_t tap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (req_taken) begin
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					send_gap = $urandom_range(0, 3);
					if ($urandom_range(0, 31) == 0)
						send_calm = $urandom_range(8, 40);
				end
			end
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (tap_queue.size() > 0) begin
				tap = tap_queue.pop_front();
				s_tdata  <= {tap.tick, tap.stamp};
				s_tuser  <= tap.ch;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: draw one stall per result once it shows up, drop ready for that long.
	always @(negedge clk) begin
		if (res_taken)
			stall_armed = 1'b0;
		if (m_tvalid && !stall_armed) begin
			stall_armed = 1'b1;
			if (recv_calm > 0) begin
				recv_calm--;
				recv_stall = 0;
			end else begin
				recv_stall = $urandom_range(0, 3);
				if ($urandom_range(0, 31) == 0)
					recv_calm = $urandom_range(8, 40);
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Give up on a hung run.
	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	task automatic add_tap(input logic [CH_IN_W-1:0] ch, input logic [STAMP_W-1:0] stamp,
	                       input logic [STAMP_W-1:0] tick);
		tap_queue.push_back('{ch: ch, stamp: stamp, tick: tick});
		taps_issued++;
	endtask

	// Hold until every request is taken and every expected result has come back.
	task automatic wait_drained();
		while (taps_done != taps_issued || pending_tempo.size() != 0)
			@(negedge clk);
	endtask

	// Write both ratio registers back to back, keeping valid high across the pair.
	task automatic set_ratio(input logic [RATIO_W-1:0] num, input logic [RATIO_W-1:0] den);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_RATIO_NUM;
		cfg_data  <= num;
		do @(negedge clk); while (!cfg_taken);
		cfg_index <= REG_RATIO_DEN;
		cfg_data  <= den;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// Mostly steady tap trains with jitter and wrap, broken up by repeats, retunes and noise.
	task automatic queue_random(input int count);
		int                 made, pick;
		logic [CH_IN_W-1:0] ch;
		logic [STAMP_W-1:0] stamp, swing;
		made = 0;
		while (made < count) begin
			ch = $urandom_range(0, CHANNELS - 1);
			if (gen_period[ch] == '0 || $urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 9))
					0:       gen_period[ch] = $urandom_range(1, 16);
					1:       gen_period[ch] = $urandom_range(1, 32'h5555_5555);
					default: gen_period[ch] = $urandom_range(50_000, 2_000_000);
				endcase
				case ($urandom_range(0, 4))
					0:       gen_spread[ch] = 2;
					1:       gen_spread[ch] = 4;
					2:       gen_spread[ch] = 8;
					3:       gen_spread[ch] = 16;
					default: gen_spread[ch] = 64;
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				swing = gen_period[ch] / gen_spread[ch];
				stamp = gen_stamp[ch] + gen_period[ch] - swing + $urandom_range(0, 2 * swing);
				made++;
			end else if (pick < 90) begin
				// repeated stamp: ignored by the block
				stamp = gen_stamp[ch];
				made++;
			end else begin
				stamp = $urandom;
				made++;
			end
			gen_stamp[ch] = stamp;
			add_tap(ch, stamp, $urandom);
		end
	endtask

	initial begin : stimulus
		logic [RATIO_W-1:0] num_list [PHASES];
		logic [RATIO_W-1:0] den_list [PHASES];
		for (int c = 0; c < CHANNELS; c++) begin
			for (int k = 0; k < RING_DEPTH; k++)
				tap_ring[c][k] = '0;
			ring_slot[c]     = '0;
			prev_stamp[c]    = '0;
			held_bpm[c]      = '0;
			held_interval[c] = '0;
			held_tick[c]     = '0;
			gen_stamp[c]     = '0;
			gen_period[c]    = '0;
			gen_spread[c]    = 4;
		end
		// Ratio settings per phase; the first runs on the reset values without a write.
		num_list = '{8'd5, 8'd255, 8'd1, 8'd1, 8'd3, 8'd17, 8'd255, 8'd128, 8'd0, 8'd5};
		den_list = '{8'd4, 8'd1, 8'd255, 8'd1, 8'd2, 8'd16, 8'd254, 8'd127, 8'd0, 8'd4};
		num_list[8] = $urandom_range(1, 255);
		den_list[8] = $urandom_range(1, 255);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset ratio 5/4.
		// A stamp of zero right after reset matches the cleared last stamp: ignored.
		add_tap(2'd0, 32'h0000_0000, 32'h1111_1111);
		add_tap(2'd0, 32'h0000_0001, 32'h2222_2222);
		add_tap(2'd0, 32'h0000_0001, 32'h3333_3333);   // repeat: ignored
		add_tap(2'd0, 32'h0000_0002, 32'h4444_4444);
		// Intervals of one: lock with an average of one, tempo at its ceiling.
		add_tap(2'd0, 32'h0000_0003, 32'h5555_5555);
		add_tap(2'd0, 32'h0000_0004, 32'hAAAA_AAAA);
		// Huge intervals across the wrap: the ratio products overflow 32 bits, tempo is zero.
		add_tap(2'd1, 32'hF000_0000, 32'h0000_0000);
		add_tap(2'd1, 32'h4000_0000, 32'h0F0F_0F0F);
		add_tap(2'd1, 32'h9000_0000, 32'hF0F0_F0F0);
		add_tap(2'd1, 32'hE000_0000, 32'h8000_0001);
		add_tap(2'd1, 32'h3000_0000, 32'h7FFF_FFFE);
		add_tap(2'd1, 32'h3000_0000, 32'h1234_5678);   // repeat after a lock
		// Steady then uneven intervals: a lock, then two of the three lock conditions failing.
		add_tap(2'd2, 32'd1000, 32'hDEAD_0001);
		add_tap(2'd2, 32'd2000, 32'hDEAD_0002);
		add_tap(2'd2, 32'd3000, 32'hDEAD_0003);
		add_tap(2'd2, 32'd4000, 32'hDEAD_0004);
		add_tap(2'd2, 32'd6000, 32'hDEAD_0005);
		add_tap(2'd2, 32'd7000, 32'hDEAD_0006);
		// Stamp train crossing the wrap from all ones, tick at all ones.
		add_tap(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_tap(2'd3, 32'h0000_01F3, 32'hFFFF_FFFF);
		add_tap(2'd3, 32'h0000_03E7, 32'hFFFF_FFFF);
		add_tap(2'd3, 32'h0000_05DB, 32'hFFFF_FFFF);
		wait_drained();

		// Random phases; hold the sender until the block is idle before each ratio change.
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0)
				set_ratio(num_list[p], den_list[p]);
			queue_random(TAPS_PER_PHASE);
			wait_drained();
		end

		// Let any stray result show up before the verdict.
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fault_count == 0 && pending_tempo.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
